>>> design/wsdf_pkg.sv
// shared types and constants of the websocket frame deframer
`default_nettype none
package wsdf_pkg;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES = 4'd4;
	localparam logic [3:0] OPCODE_TEXT = 4'd1;
	localparam logic [3:0] OPCODE_BINARY = 4'd2;
	localparam int TUSER_W = 6;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       message_end;
		logic [3:0] message_opcode;
		logic       opcode_bad;
	} result_t;

endpackage
`default_nettype wire

>>> design/wsdf_out_reg.sv
// output register stage with handshake toward the master side
`default_nettype none
module wsdf_out_reg (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      load,
	input  wsdf_pkg::result_t        res,
	output logic                     free,
	output logic                     m_axis_tvalid,
	input  wire                      m_axis_tready,
	output logic [7:0]               m_axis_tdata,  // out_byte
	output logic                     m_axis_tlast,
	output logic [wsdf_pkg::TUSER_W-1:0] m_axis_tuser // has_byte, message_opcode, opcode_bad
);
	import wsdf_pkg::*;

	result_t res_q;
	logic    valid_q;

	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = res_q.out_byte;
	assign m_axis_tlast  = res_q.message_end;
	assign m_axis_tuser  = {res_q.opcode_bad, res_q.message_opcode, res_q.has_byte};

endmodule
`default_nettype wire

>>> design/websocket_frame_deframer_unit.sv
// websocket frame deframer: header parse, unmask and fragment join
//
// channel  dir  tdata          tuser                                   tlast
// s_axis   in   in_byte[7:0]   -                                       -
// m_axis   out  out_byte[7:0]  has_byte, message_opcode, opcode_bad    message_end
//
// one byte accepted per cycle while s_axis_tready is high
// its result sits in the output register next cycle, which drives m_axis_tvalid
// header bytes give no output word, except the bare end marker of an empty final frame
// s_axis_tready drops only while a result waits and m_axis_tready is low
// arst_n returns the parser to the first header byte with no message open
`default_nettype none
module websocket_frame_deframer_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire  [7:0]                   s_axis_tdata,  // in_byte
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [7:0]                   m_axis_tdata,  // out_byte
	output logic                         m_axis_tlast,  // message_end
	output logic [wsdf_pkg::TUSER_W-1:0] m_axis_tuser   // has_byte, message_opcode[3:0], opcode_bad
);
	import wsdf_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT     = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  ext_q, ext_n;
	logic [63:0] plen_q, plen_n;
	logic [31:0] key_q, key_n;
	logic [1:0]  kidx_q, kidx_n;
	logic        fin_q, fin_n;
	logic        mask_q, mask_n;
	logic [3:0]  op_q, op_n;
	logic        frag_q, frag_n;

	logic        accept;
	logic        out_free;
	logic        res_valid;
	result_t     res;
	logic        hdr_done;
	logic        hdr_mask;
	logic [7:0]  b;
	logic [6:0]  len7;
	logic [1:0]  ksel;

	assign s_axis_tready = out_free;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign b = s_axis_tdata;
	assign len7 = b[6:0];
	assign ksel = ~kidx_q;

	always_comb begin
		phase_n   = phase_q;
		ext_n     = ext_q;
		plen_n    = plen_q;
		key_n     = key_q;
		kidx_n    = kidx_q;
		fin_n     = fin_q;
		mask_n    = mask_q;
		op_n      = op_q;
		frag_n    = frag_q;
		hdr_done  = 1'b0;
		hdr_mask  = 1'b0;
		res_valid = 1'b0;
		res.out_byte    = 8'd0;
		res.has_byte    = 1'b0;
		res.message_end = 1'b0;

		case (phase_q)
			PH_HDR1: begin
				mask_n = b[7];
				plen_n = 64'd0;
				if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
					ext_n   = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					phase_n = PH_EXT;
				end else begin
					plen_n   = {57'd0, len7};
					hdr_done = 1'b1;
					hdr_mask = b[7];
				end
			end
			PH_EXT: begin
				plen_n = {plen_q[55:0], b};
				ext_n  = ext_q - 4'd1;
				if (ext_n == 4'd0) begin
					hdr_done = 1'b1;
					hdr_mask = mask_q;
				end
			end
			PH_MASK: begin
				key_n = {key_q[23:0], b};
				ext_n = ext_q - 4'd1;
				if (ext_n == 4'd0) begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				res_valid    = 1'b1;
				res.has_byte = 1'b1;
				res.out_byte = mask_q ? (b ^ key_q[{ksel, 3'b000} +: 8]) : b;
				kidx_n = kidx_q + 2'd1;
				plen_n = plen_q - 64'd1;
				if (plen_q == 64'd1) begin
					phase_n = PH_HDR0;
					if (fin_q) begin
						res.message_end = 1'b1;
						frag_n = 1'b0;
					end
				end
			end
			default: begin
				fin_n = b[7];
				if (!frag_q) begin
					op_n   = b[3:0];
					frag_n = 1'b1;
				end
				phase_n = PH_HDR1;
			end
		endcase

		if (hdr_done) begin
			if (hdr_mask) begin
				ext_n   = KEY_BYTES;
				phase_n = PH_MASK;
			end else begin
				kidx_n = 2'd0;
				if (plen_n != 64'd0) begin
					phase_n = PH_PAYLOAD;
				end else begin
					phase_n = PH_HDR0;
					if (fin_q) begin
						res_valid       = 1'b1;
						res.message_end = 1'b1;
						frag_n          = 1'b0;
					end
				end
			end
		end

		res.message_opcode = op_q;
		res.opcode_bad = res.message_end && op_q != OPCODE_TEXT && op_q != OPCODE_BINARY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			ext_q   <= 4'd0;
			plen_q  <= 64'd0;
			key_q   <= 32'd0;
			kidx_q  <= 2'd0;
			fin_q   <= 1'b0;
			mask_q  <= 1'b0;
			op_q    <= 4'd0;
			frag_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			ext_q   <= ext_n;
			plen_q  <= plen_n;
			key_q   <= key_n;
			kidx_q  <= kidx_n;
			fin_q   <= fin_n;
			mask_q  <= mask_n;
			op_q    <= op_n;
			frag_q  <= frag_n;
		end
	end

	wsdf_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept && res_valid),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire

>>> design/wsdf_checker.sv
// port-level checks of the websocket frame deframer and their bind
`default_nettype none
module wsdf_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_axis_tready,
	input wire                          m_axis_tvalid,
	input wire                          m_axis_tready,
	input wire [7:0]                    m_axis_tdata,
	input wire                          m_axis_tlast,
	input wire [wsdf_pkg::TUSER_W-1:0]  m_axis_tuser
);
	import wsdf_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	a_bare_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'd0)
		else $error("word without payload is not a clean end marker");

	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[5] |-> m_axis_tlast)
		else $error("bad opcode flagged before message end");

	a_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[5] ==
			(m_axis_tuser[4:1] != OPCODE_TEXT && m_axis_tuser[4:1] != OPCODE_BINARY))
		else $error("bad opcode flag disagrees with message opcode");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind websocket_frame_deframer_unit wsdf_checker u_wsdf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
